// ===== rtl/core/rbm_pkg.sv =====
// Package: shared types and constants of the ROM bank mapper.
`default_nettype none

package rbm_pkg;

    typedef logic [2:0] kind_t;

    localparam kind_t KIND_DATA     = 3'd0;
    localparam kind_t KIND_ROM      = 3'd1;
    localparam kind_t KIND_FORWARD  = 3'd2;
    localparam kind_t KIND_ABSORBED = 3'd3;
    localparam kind_t KIND_REJECTED = 3'd4;

    // address[15:13] region codes
    localparam logic [2:0] REGION_CTRL_EN   = 3'd0;
    localparam logic [2:0] REGION_CTRL_BANK = 3'd1;
    localparam logic [2:0] REGION_ROM_LO    = 3'd2;
    localparam logic [2:0] REGION_ROM_HI    = 3'd3;
    localparam logic [2:0] REGION_RAM       = 3'd5;

    localparam int          CTRL_BIT      = 8;
    localparam logic [3:0]  RAM_EN_CODE   = 4'hA;
    localparam logic [7:0]  RAM_OFF_BYTE  = 8'hFF;
    localparam logic [3:0]  BANK_RESET    = 4'h1;
    localparam logic [3:0]  MASK_RESET    = 4'hF;

    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    typedef struct packed {
        logic        opcode;
        logic [15:0] address;
        logic [7:0]  write_data;
    } req_t;

    typedef struct packed {
        kind_t       result_kind;
        logic [7:0]  read_data;
        logic [17:0] rom_address;
        logic [15:0] forward_address;
        logic [7:0]  forward_data;
        logic        ram_lock_event;
    } rsp_t;

endpackage

`default_nettype wire

// ===== rtl/core/rbm_if.sv =====
// Interfaces: bus access request channel and result channel.
`default_nettype none

interface rbm_req_if;
    import rbm_pkg::*;

    logic valid;
    logic ready;
    req_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface rbm_rsp_if;
    import rbm_pkg::*;

    logic valid;
    logic ready;
    rsp_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/rom_bank_mapper_with_nibble_ram.sv =====
// Top level: banked ROM mapper with built-in nibble RAM, one access per beat.
//
// Takes one bus access beat per cycle while the result side does not stall, and returns
// one result beat for each, in order. The nibble RAM read port is registered alongside
// the request, the decode and state update run on the registered request, and the
// result lands in an output register. After reset a clearing pass writes zero to every
// RAM entry, one per cycle, during which no request beat is accepted; configuration
// writes are taken throughout. A RAM write immediately followed by a read of the same
// entry is served by a bypass, so back-to-back beats see each other's effects.
`default_nettype none

module rom_bank_mapper_with_nibble_ram #(
    parameter int RAM_DEPTH = 512
) (
    input  wire          clk,
    input  wire          rst_n,
    rbm_req_if.sink      req,
    rbm_rsp_if.source    rsp,
    input  wire          cfg_we,
    input  wire [3:0]    cfg_wdata
);
    import rbm_pkg::*;

    localparam int RamAw = $clog2(RAM_DEPTH);

    logic [3:0]       mem [RAM_DEPTH];
    logic [3:0]       ram_rd_reg;
    logic             mem_we;
    logic [RamAw-1:0] mem_waddr;
    logic [3:0]       mem_wdata;

    logic [RamAw:0]   clr_cnt_reg;
    logic             clr_busy;

    logic [3:0]       mask_reg;
    logic [3:0]       bank_reg, bank_next;
    logic             ram_en_reg, ram_en_next;

    logic             s1_valid_reg;
    req_t             s1_req_reg;
    logic             byp_reg;
    logic [3:0]       byp_data_reg;

    logic             out_valid_reg;
    rsp_t             out_reg, out_next;

    logic             req_fire;
    logic             s1_adv;
    logic [2:0]       region;
    logic             in_ram;
    logic             ram_wr;
    logic [3:0]       ram_q;
    logic [3:0]       bank_sel;

    assign clr_busy = (clr_cnt_reg != (RamAw+1)'(RAM_DEPTH));
    assign s1_adv   = s1_valid_reg && (!out_valid_reg || rsp.ready);
    assign req.ready = !clr_busy && (!s1_valid_reg || s1_adv);
    assign req_fire = req.valid && req.ready;

    assign region = s1_req_reg.address[15:13];
    assign in_ram = (region == REGION_RAM)
                 && ({3'b000, s1_req_reg.address[12:0]} < 16'(RAM_DEPTH));
    assign ram_wr = (s1_req_reg.opcode == OP_WRITE) && in_ram && ram_en_reg;
    assign ram_q  = byp_reg ? byp_data_reg : ram_rd_reg;

    always_comb
    begin
        bank_sel = s1_req_reg.write_data[3:0];
        if (bank_sel == 4'h0)
            bank_sel = BANK_RESET;
    end

    always_comb
    begin
        out_next                 = '0;
        out_next.result_kind     = KIND_REJECTED;
        bank_next                = bank_reg;
        ram_en_next              = ram_en_reg;
        if (s1_req_reg.opcode == OP_READ)
        begin
            unique case (region) inside
                REGION_ROM_LO, REGION_ROM_HI:
                begin
                    out_next.result_kind = KIND_ROM;
                    out_next.rom_address = {bank_reg, s1_req_reg.address[13:0]};
                end
                REGION_RAM:
                begin
                    out_next.result_kind = KIND_DATA;
                    if (in_ram)
                        out_next.read_data = ram_en_reg ? {4'h0, ram_q} : RAM_OFF_BYTE;
                end
                default:
                begin
                    out_next.result_kind     = KIND_FORWARD;
                    out_next.forward_address = s1_req_reg.address;
                end
            endcase
        end
        else
        begin
            unique case (region) inside
                REGION_CTRL_EN:
                begin
                    if (!s1_req_reg.address[CTRL_BIT])
                    begin
                        ram_en_next             = (s1_req_reg.write_data[3:0] == RAM_EN_CODE);
                        out_next.ram_lock_event = ram_en_reg && !ram_en_next;
                        out_next.result_kind    = KIND_ABSORBED;
                    end
                end
                REGION_CTRL_BANK:
                begin
                    if (s1_req_reg.address[CTRL_BIT])
                    begin
                        bank_next            = bank_sel & mask_reg;
                        out_next.result_kind = KIND_ABSORBED;
                    end
                end
                REGION_ROM_LO, REGION_ROM_HI:
                    out_next.result_kind = KIND_REJECTED;
                REGION_RAM:
                begin
                    if (ram_wr)
                        out_next.result_kind = KIND_ABSORBED;
                end
                default:
                begin
                    out_next.result_kind     = KIND_FORWARD;
                    out_next.forward_address = s1_req_reg.address;
                    out_next.forward_data    = s1_req_reg.write_data;
                end
            endcase
        end
    end

    // write port: clearing pass after reset, otherwise committed RAM writes
    always_comb
    begin
        if (clr_busy)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_cnt_reg[RamAw-1:0];
            mem_wdata = 4'h0;
        end
        else
        begin
            mem_we    = s1_adv && ram_wr;
            mem_waddr = s1_req_reg.address[RamAw-1:0];
            mem_wdata = s1_req_reg.write_data[3:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        if (req_fire)
            ram_rd_reg <= mem[req.data.address[RamAw-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            s1_req_reg   <= req.data;
            byp_reg      <= s1_adv && ram_wr
                         && (s1_req_reg.address[RamAw-1:0] == req.data.address[RamAw-1:0]);
            byp_data_reg <= s1_req_reg.write_data[3:0];
        end
        if (s1_adv)
            out_reg <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg   <= '0;
            mask_reg      <= MASK_RESET;
            bank_reg      <= BANK_RESET;
            ram_en_reg    <= 1'b0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (clr_busy)
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            if (cfg_we)
                mask_reg <= cfg_wdata;
            if (s1_adv)
            begin
                bank_reg   <= bank_next;
                ram_en_reg <= ram_en_next;
            end
            if (req_fire)
                s1_valid_reg <= 1'b1;
            else if (s1_adv)
                s1_valid_reg <= 1'b0;
            if (s1_adv)
                out_valid_reg <= 1'b1;
            else if (rsp.ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_reg;

endmodule

`default_nettype wire

// ===== rtl/core/rbm_checker.sv =====
// Checker: port-level properties of the ROM bank mapper, bound to the top level.
`default_nettype none

module rbm_checker (
    input  wire          clk,
    input  wire          rst_n,
    rbm_req_if.sink      req,
    rbm_rsp_if.source    rsp
);
    import rbm_pkg::*;

    // stalled result beat stays
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.data))
        else $error("result beat dropped or changed under stall");

    a_lock_kind: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.data.ram_lock_event |-> rsp.data.result_kind == KIND_ABSORBED)
        else $error("lock pulse on a beat that is not an absorbed write");

    a_fwd_clean: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.data.result_kind != KIND_FORWARD
        |-> rsp.data.forward_address == 16'h0 && rsp.data.forward_data == 8'h0)
        else $error("forward fields set on a non-forwarded beat");

    a_ram_nibble: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.data.result_kind == KIND_DATA
        |-> rsp.data.read_data[7:4] == 4'h0 || rsp.data.read_data == RAM_OFF_BYTE)
        else $error("RAM read with bad upper nibble");

    a_rom_addr: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.data.result_kind != KIND_ROM |-> rsp.data.rom_address == 18'h0)
        else $error("ROM address set on a non-ROM beat");

endmodule

bind rom_bank_mapper_with_nibble_ram rbm_checker u_rbm_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (req),
    .rsp       (rsp)
);

`default_nettype wire

// ===== verif/rom_bank_mapper_with_nibble_ram_test.sv =====
// Self-checking test of the ROM bank mapper: a shadow mapper predicts every result beat.
`default_nettype none

module rom_bank_mapper_with_nibble_ram_test;
    import rbm_pkg::*;

    localparam int          RAM_DEPTH = 512;
    localparam logic [15:0] RAM_END   = 16'hA200;
    localparam int          PHASES    = 7;
    localparam int          PHASE_LEN = 250;

    class access_scoreboard;
        logic [3:0] bank_mask;
        logic [3:0] bank;
        bit         ram_on;
        logic [3:0] nibbles [RAM_DEPTH];
        rsp_t       expected_q [$];
        int         errors;

        function new();
            bank_mask = MASK_RESET;
            bank = BANK_RESET;
            ram_on = 1'b0;
            foreach (nibbles[i]) nibbles[i] = 4'h0;
            errors = 0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void note_access(req_t a);
            rsp_t       e;
            logic [2:0] region;
            logic       ctrl;
            logic [3:0] sel;
            e = '0;
            e.result_kind = KIND_REJECTED;
            region = a.address[15:13];
            ctrl = a.address[CTRL_BIT];
            if (a.opcode == OP_READ)
            begin
                if (region == REGION_ROM_LO || region == REGION_ROM_HI)
                begin
                    e.result_kind = KIND_ROM;
                    e.rom_address = {bank, a.address[13:0]};
                end
                else if (region == REGION_RAM)
                begin
                    e.result_kind = KIND_DATA;
                    if (a.address < RAM_END)
                        e.read_data = ram_on ? {4'h0, nibbles[a.address[8:0]]} : RAM_OFF_BYTE;
                    else
                        e.read_data = 8'h00;
                end
                else
                begin
                    e.result_kind = KIND_FORWARD;
                    e.forward_address = a.address;
                end
            end
            else
            begin
                case (region) inside
                    REGION_CTRL_EN:
                        if (!ctrl)
                        begin
                            e.ram_lock_event = ram_on && (a.write_data[3:0] != RAM_EN_CODE);
                            ram_on = (a.write_data[3:0] == RAM_EN_CODE);
                            e.result_kind = KIND_ABSORBED;
                        end
                    REGION_CTRL_BANK:
                        if (ctrl)
                        begin
                            sel = (a.write_data[3:0] == 4'h0) ? BANK_RESET : a.write_data[3:0];
                            bank = sel & bank_mask;
                            e.result_kind = KIND_ABSORBED;
                        end
                    REGION_ROM_LO, REGION_ROM_HI: ;
                    REGION_RAM:
                        if (a.address < RAM_END && ram_on)
                        begin
                            nibbles[a.address[8:0]] = a.write_data[3:0];
                            e.result_kind = KIND_ABSORBED;
                        end
                    default:
                    begin
                        e.result_kind = KIND_FORWARD;
                        e.forward_address = a.address;
                        e.forward_data = a.write_data;
                    end
                endcase
            end
            expected_q.push_back(e);
        endfunction

        function void compare_field(string name, logic [17:0] exp_v, logic [17:0] act_v);
            if (exp_v !== act_v)
            begin
                errors++;
                $display("%0t mismatch %s: expected %h actual %h", $time, name, exp_v, act_v);
            end
        endfunction

        function void check_result(rsp_t got);
            rsp_t e;
            if (expected_q.size() == 0)
            begin
                errors++;
                $display("%0t unexpected result beat: expected none actual %h", $time, got);
                return;
            end
            e = expected_q.pop_front();
            compare_field("result_kind", 18'(e.result_kind), 18'(got.result_kind));
            compare_field("read_data", 18'(e.read_data), 18'(got.read_data));
            compare_field("rom_address", e.rom_address, got.rom_address);
            compare_field("forward_address", 18'(e.forward_address),
                          18'(got.forward_address));
            compare_field("forward_data", 18'(e.forward_data), 18'(got.forward_data));
            compare_field("ram_lock_event", 18'(e.ram_lock_event), 18'(got.ram_lock_event));
        endfunction
    endclass

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    logic [3:0] cfg_wdata;
    bit         idling;

    rbm_req_if req_ch ();
    rbm_rsp_if rsp_ch ();

    access_scoreboard sb = new();

    rom_bank_mapper_with_nibble_ram #(
        .RAM_DEPTH(RAM_DEPTH)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .req(req_ch),
        .rsp(rsp_ch),
        .cfg_we(cfg_we),
        .cfg_wdata(cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req_ch.valid && req_ch.ready) sb.note_access(req_ch.data);
            if (rsp_ch.valid && rsp_ch.ready) sb.check_result(rsp_ch.data);
        end
    end

    // result-side backpressure
    initial
    begin
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (!idling || $urandom_range(0, 11) != 0)
                rsp_ch.ready <= 1'b1;
            else
            begin
                rsp_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge clk);
                rsp_ch.ready <= 1'b1;
            end
        end
    end

    task automatic write_mask(input logic [3:0] m);
        cfg_we <= 1'b1;
        cfg_wdata <= m;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.bank_mask = m;
    endtask

    task automatic drain();
        @(posedge clk);
        while (sb.pending() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic send_access(input req_t a);
        if (idling && $urandom_range(0, 7) == 0)
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.data <= a;
        @(posedge clk);
        while (!req_ch.ready) @(posedge clk);
    endtask

    function automatic req_t random_access();
        req_t a;
        int   pick;
        a.opcode = 1'($urandom_range(0, 1));
        a.address = 16'($urandom_range(0, 16'hFFFF));
        a.write_data = 8'($urandom_range(0, 255));
        pick = $urandom_range(0, 99);
        if (pick < 10)
        begin
            a.opcode = OP_WRITE;
            a.address[15:13] = REGION_CTRL_EN;
            a.address[CTRL_BIT] = 1'b0;
            if ($urandom_range(0, 3) != 0) a.write_data[3:0] = RAM_EN_CODE;
        end
        else if (pick < 18)
        begin
            a.opcode = OP_WRITE;
            a.address[15:13] = REGION_CTRL_BANK;
            a.address[CTRL_BIT] = 1'b1;
        end
        else if (pick < 28)
        begin
            a.opcode = OP_READ;
            a.address[15:14] = 2'b01;
        end
        else if (pick < 58)
        begin
            // small window half the time so reads hit written entries
            if ($urandom_range(0, 1) == 0)
                a.address = 16'hA000 + 16'($urandom_range(0, 15));
            else
                a.address = 16'hA000 + 16'($urandom_range(0, RAM_DEPTH - 1));
        end
        else if (pick < 64)
            a.address = 16'($urandom_range(RAM_END, 16'hBFFF));
        else if (pick < 72)
        begin
            a.opcode = OP_WRITE;
            a.address[15:14] = 2'b00;
            a.address[CTRL_BIT] = ~a.address[13];
        end
        else if (pick < 76)
        begin
            a.opcode = OP_WRITE;
            a.address[15:14] = 2'b01;
        end
        return a;
    endfunction

    initial
    begin
        logic [3:0] masks [PHASES];
        masks = '{4'hF, 4'h0, 4'h7, 4'h1, 4'h5, 4'h3, 4'hF};
        req_ch.valid <= 1'b0;
        req_ch.data <= '0;
        cfg_we <= 1'b0;
        cfg_wdata <= 4'h0;
        rst_n <= 1'b0;
        idling = 1'b1;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        for (int ph = 0; ph < PHASES; ph++)
        begin
            idling = (ph != 2) && (ph != PHASES - 1);
            if (ph == 4)
                write_mask(4'($urandom_range(0, 15)));
            else
                write_mask(masks[ph]);
            if (ph == 0)
            begin
                send_access(req_t'{OP_READ,  16'h4000, 8'h00});
                send_access(req_t'{OP_READ,  16'h7FFF, 8'hFF});
                send_access(req_t'{OP_READ,  16'hA000, 8'h00});
                send_access(req_t'{OP_WRITE, 16'hA000, 8'h5C});
                send_access(req_t'{OP_WRITE, 16'h0000, 8'h0A});
                send_access(req_t'{OP_WRITE, 16'hA000, 8'hFF});
                send_access(req_t'{OP_READ,  16'hA000, 8'h00});
                send_access(req_t'{OP_WRITE, 16'hA1FF, 8'h35});
                send_access(req_t'{OP_READ,  16'hA1FF, 8'h00});
                send_access(req_t'{OP_READ,  16'hA200, 8'h00});
                send_access(req_t'{OP_WRITE, 16'hBFFF, 8'h12});
                send_access(req_t'{OP_WRITE, 16'h2100, 8'h00});
                send_access(req_t'{OP_READ,  16'h4001, 8'h00});
                send_access(req_t'{OP_WRITE, 16'h3FFF, 8'hFF});
                send_access(req_t'{OP_READ,  16'h4123, 8'h00});
                send_access(req_t'{OP_WRITE, 16'h2000, 8'h05});
                send_access(req_t'{OP_WRITE, 16'h0100, 8'h0A});
                send_access(req_t'{OP_WRITE, 16'h5555, 8'hAA});
                send_access(req_t'{OP_READ,  16'h0000, 8'h00});
                send_access(req_t'{OP_READ,  16'h3FFF, 8'h00});
                send_access(req_t'{OP_WRITE, 16'h8000, 8'hFF});
                send_access(req_t'{OP_READ,  16'hFFFF, 8'h00});
                send_access(req_t'{OP_WRITE, 16'hC123, 8'h80});
                send_access(req_t'{OP_WRITE, 16'h1EFF, 8'h1A});
                send_access(req_t'{OP_WRITE, 16'h0000, 8'h0B});
                send_access(req_t'{OP_READ,  16'hA1FF, 8'h00});
            end
            for (int i = 0; i < PHASE_LEN; i++)
            begin
                if (ph == 3 && i == PHASE_LEN / 2)
                begin
                    req_ch.valid <= 1'b0;
                    drain();
                end
                send_access(random_access());
            end
            req_ch.valid <= 1'b0;
            drain();
        end

        if (sb.errors == 0 && sb.pending() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

`default_nettype wire
